// File: hw/rtl/gpsm_pkg.sv
// Shared constants, result type and helpers for the game controller poll master.
package gpsm_pkg;

    localparam int FRAME_BYTES_DEF = 9;
    localparam int TICK_W          = 16;
    localparam int CFG_INDEX_W     = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_HALF_BIT     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SELECT_GUARD = 1'b1;

    localparam logic [TICK_W-1:0] TICKS_RESET = 16'd16;

    localparam logic [7:0] CMD_FIRST    = 8'h01;
    localparam logic [7:0] CMD_SECOND   = 8'h42;
    localparam logic [7:0] STATUS_READY = 8'h5A;

    typedef struct packed {
        logic        chip_select_n;
        logic        serial_clock;
        logic        command_out;
        logic        frame_done;
        logic        connected;
        logic [7:0]  mode_id;
        logic [15:0] buttons;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
        logic        report_changed;
    } gpsm_result_t;

    function automatic logic [TICK_W-1:0] load_ticks(input logic [TICK_W-1:0] n);
        return (n == '0) ? TICK_W'(1) : n;
    endfunction

endpackage

// File: hw/rtl/gpsm_seq.sv
// Pin-level poll sequencer: timing registers, frame state and report staging.
module gpsm_seq
    import gpsm_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   start_req,
    input  logic                   data_in,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]      cfg_data,
    output gpsm_result_t           res_next
);

    localparam int BYTE_W = $clog2(FRAME_BYTES + 1);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_SETUP   = 3'd1;
    localparam logic [2:0] PH_HIGH    = 3'd2;
    localparam logic [2:0] PH_LOW     = 3'd3;
    localparam logic [2:0] PH_RELEASE = 3'd4;

    logic [TICK_W-1:0] half_bit_reg;
    logic [TICK_W-1:0] guard_reg;

    logic [2:0]        phase_reg,  phase_next;
    logic [TICK_W-1:0] wait_reg,   wait_next;
    logic [2:0]        bit_reg,    bit_next;
    logic [BYTE_W-1:0] byte_reg,   byte_next;
    logic [7:0]        shift_reg,  shift_next;
    logic [7:0]        mode_reg,   mode_next;
    logic              status_reg, status_next;
    logic [15:0]       btn_reg,    btn_next;
    logic [7:0]        stick_reg  [4];
    logic [7:0]        stick_next [4];
    logic [47:0]       prev_reg,   prev_next;
    logic [7:0]        rep_mode_reg, rep_mode_next;
    logic              rep_conn_reg, rep_conn_next;
    logic              cs_n_reg,   cs_n_next;
    logic              sclk_reg,   sclk_next;
    logic              cmd_reg,    cmd_next;

    logic              done;
    logic              changed;
    logic              expired;
    logic [7:0]        pos_ext;
    logic [7:0]        cmd_byte;
    logic [47:0]       report;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_bit_reg <= TICKS_RESET;
            guard_reg    <= TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HALF_BIT:     half_bit_reg <= cfg_data;
                REG_SELECT_GUARD: guard_reg    <= cfg_data;
                default:          half_bit_reg <= half_bit_reg;
            endcase
        end
    end

    assign expired = (wait_reg <= TICK_W'(1));
    assign report  = {stick_reg[1], stick_reg[0], stick_reg[3], stick_reg[2], btn_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        wait_next     = wait_reg;
        bit_next      = bit_reg;
        byte_next     = byte_reg;
        shift_next    = shift_reg;
        mode_next     = mode_reg;
        status_next   = status_reg;
        btn_next      = btn_reg;
        stick_next    = stick_reg;
        prev_next     = prev_reg;
        rep_mode_next = rep_mode_reg;
        rep_conn_next = rep_conn_reg;
        cs_n_next     = cs_n_reg;
        sclk_next     = sclk_reg;
        cmd_next      = cmd_reg;
        done          = 1'b0;
        changed       = 1'b0;
        pos_ext       = 8'(byte_reg);
        cmd_byte      = 8'h00;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    mode_next   = 8'h00;
                    status_next = 1'b0;
                    btn_next    = 16'h0000;
                    for (int k = 0; k < 4; k++)
                    begin
                        stick_next[k] = 8'h00;
                    end
                    shift_next  = 8'h00;
                    bit_next    = 3'd0;
                    byte_next   = '0;
                    cs_n_next   = 1'b0;
                    sclk_next   = 1'b1;
                    wait_next   = load_ticks(guard_reg);
                    phase_next  = PH_SETUP;
                end
            end
            PH_SETUP:
            begin
                if (expired)
                begin
                    phase_next = PH_HIGH;
                end
                else
                begin
                    wait_next = wait_reg - TICK_W'(1);
                end
            end
            PH_HIGH:
            begin
                if (expired)
                begin
                    sclk_next = 1'b0;
                    if (data_in)
                    begin
                        shift_next[bit_reg] = 1'b1;
                    end
                    wait_next  = load_ticks(half_bit_reg);
                    phase_next = PH_LOW;
                end
                else
                begin
                    wait_next = wait_reg - TICK_W'(1);
                end
            end
            PH_LOW:
            begin
                if (expired)
                begin
                    sclk_next = 1'b1;
                    if (bit_reg == 3'd7)
                    begin
                        if (pos_ext == 8'd1)
                        begin
                            mode_next = shift_reg;
                        end
                        if (pos_ext == 8'd2)
                        begin
                            status_next = (shift_reg == STATUS_READY);
                        end
                        if (pos_ext == 8'd3)
                        begin
                            btn_next[7:0] = shift_reg;
                        end
                        if (pos_ext == 8'd4)
                        begin
                            btn_next[15:8] = shift_reg;
                        end
                        for (int k = 0; k < 4; k++)
                        begin
                            if (pos_ext == 8'(5 + k))
                            begin
                                stick_next[k] = shift_reg;
                            end
                        end
                        shift_next = 8'h00;
                        bit_next   = 3'd0;
                        byte_next  = byte_reg + BYTE_W'(1);
                        if (byte_next >= BYTE_W'(FRAME_BYTES))
                        begin
                            cs_n_next  = 1'b1;
                            wait_next  = load_ticks(guard_reg);
                            phase_next = PH_RELEASE;
                        end
                        else
                        begin
                            phase_next = PH_HIGH;
                        end
                    end
                    else
                    begin
                        bit_next   = bit_reg + 3'd1;
                        phase_next = PH_HIGH;
                    end
                end
                else
                begin
                    wait_next = wait_reg - TICK_W'(1);
                end
            end
            PH_RELEASE:
            begin
                if (expired)
                begin
                    changed       = (report != prev_reg);
                    prev_next     = report;
                    rep_conn_next = status_reg;
                    rep_mode_next = status_reg ? mode_reg : 8'h00;
                    done          = 1'b1;
                    phase_next    = PH_IDLE;
                end
                else
                begin
                    wait_next = wait_reg - TICK_W'(1);
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (phase_next == PH_HIGH && phase_reg != PH_HIGH)
        begin
            if (byte_next == BYTE_W'(0))
            begin
                cmd_byte = CMD_FIRST;
            end
            else if (byte_next == BYTE_W'(1))
            begin
                cmd_byte = CMD_SECOND;
            end
            cmd_next  = cmd_byte[bit_next];
            sclk_next = 1'b1;
            wait_next = load_ticks(half_bit_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            wait_reg     <= '0;
            bit_reg      <= 3'd0;
            byte_reg     <= '0;
            shift_reg    <= 8'h00;
            mode_reg     <= 8'h00;
            status_reg   <= 1'b0;
            btn_reg      <= 16'h0000;
            for (int k = 0; k < 4; k++)
            begin
                stick_reg[k] <= 8'h00;
            end
            prev_reg     <= '0;
            rep_mode_reg <= 8'h00;
            rep_conn_reg <= 1'b0;
            cs_n_reg     <= 1'b1;
            sclk_reg     <= 1'b1;
            cmd_reg      <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            wait_reg     <= wait_next;
            bit_reg      <= bit_next;
            byte_reg     <= byte_next;
            shift_reg    <= shift_next;
            mode_reg     <= mode_next;
            status_reg   <= status_next;
            btn_reg      <= btn_next;
            stick_reg    <= stick_next;
            prev_reg     <= prev_next;
            rep_mode_reg <= rep_mode_next;
            rep_conn_reg <= rep_conn_next;
            cs_n_reg     <= cs_n_next;
            sclk_reg     <= sclk_next;
            cmd_reg      <= cmd_next;
        end
    end

    always_comb
    begin
        res_next.chip_select_n  = cs_n_next;
        res_next.serial_clock   = sclk_next;
        res_next.command_out    = cmd_next;
        res_next.frame_done     = done;
        res_next.connected      = rep_conn_next;
        res_next.mode_id        = rep_mode_next;
        res_next.buttons        = prev_next[15:0];
        res_next.left_x         = prev_next[23:16];
        res_next.left_y         = prev_next[31:24];
        res_next.right_x        = prev_next[39:32];
        res_next.right_y        = prev_next[47:40];
        res_next.report_changed = changed;
    end

endmodule

// File: hw/rtl/gamepad_poll_serial_master_top.sv
// Top level of the game controller poll master: request handshake and result register.
// The result of each accepted request is registered and held until the next accepted request.
// Throughput: one request per clock while the output is not stalled; the result register alone parts the two sides.
// Reset: idle, select high, clock high, data low, report cleared, both timings 16.
module gamepad_poll_serial_master_top
    import gpsm_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   start_req,
    input  logic                   data_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   chip_select_n,
    output logic                   serial_clock,
    output logic                   command_out,
    output logic                   frame_done,
    output logic                   connected,
    output logic [7:0]             mode_id,
    output logic [15:0]            buttons,
    output logic [7:0]             left_x,
    output logic [7:0]             left_y,
    output logic [7:0]             right_x,
    output logic [7:0]             right_y,
    output logic                   report_changed,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]      cfg_data
);

    logic         accept;
    logic         valid_reg;
    gpsm_result_t res_next;
    gpsm_result_t res_reg;

    assign in_stall = valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    gpsm_seq #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .start_req (start_req),
        .data_in   (data_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_next  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '{chip_select_n: 1'b1, serial_clock: 1'b1, default: '0};
        end
        else if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = valid_reg;
    assign chip_select_n  = res_reg.chip_select_n;
    assign serial_clock   = res_reg.serial_clock;
    assign command_out    = res_reg.command_out;
    assign frame_done     = res_reg.frame_done;
    assign connected      = res_reg.connected;
    assign mode_id        = res_reg.mode_id;
    assign buttons        = res_reg.buttons;
    assign left_x         = res_reg.left_x;
    assign left_y         = res_reg.left_y;
    assign right_x        = res_reg.right_x;
    assign right_y        = res_reg.right_y;
    assign report_changed = res_reg.report_changed;

endmodule

// File: hw/rtl/gpsm_checker.sv
// Port-level checks for the poll master, bound to the top level.
module gpsm_checker
    import gpsm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        chip_select_n,
    input logic        serial_clock,
    input logic        frame_done,
    input logic        connected,
    input logic [7:0]  mode_id,
    input logic [15:0] buttons,
    input logic        report_changed
);

    a_done_lines_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> (chip_select_n && serial_clock))
        else $error("frame completed with select or clock low");

    a_changed_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && report_changed) |-> frame_done)
        else $error("report change flagged outside frame completion");

    a_mode_needs_link: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !connected) |-> (mode_id == 8'h00))
        else $error("mode reported without a connected controller");

    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(buttons) && $stable(frame_done)))
        else $error("stalled result changed");

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("request stalled with no result waiting");

endmodule

bind gamepad_poll_serial_master_top gpsm_checker u_gpsm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .chip_select_n  (chip_select_n),
    .serial_clock   (serial_clock),
    .frame_done     (frame_done),
    .connected      (connected),
    .mode_id        (mode_id),
    .buttons        (buttons),
    .report_changed (report_changed)
);
